// File: hw/rtl/mpc_pkg.sv
// ----------------------------------------------------------------------------
// mpc_pkg
// Shared types, register map and helper functions for the moisture pump
// controller: word layouts, reset values and seven-segment encoding.
// ----------------------------------------------------------------------------
package mpc_pkg;

  // Default width of the used part of a soil reading
  localparam int SAMPLE_BITS_DEF = 10;

  // Field widths
  localparam int SoilW   = 10;
  localparam int SetW    = 7;
  localparam int SegW    = 7;
  localparam int SPerW   = 8;
  localparam int ScrPerW = 10;

  // Register map (index = paddr[3:2])
  localparam logic [1:0] RegSamplePeriod = 2'd0;
  localparam logic [1:0] RegScreenPeriod = 2'd1;
  localparam logic [1:0] RegSetpointMin  = 2'd2;
  localparam logic [1:0] RegSetpointMax  = 2'd3;

  // Reset values
  localparam logic [SPerW-1:0]   SamplePeriodRst = 8'd50;
  localparam logic [ScrPerW-1:0] ScreenPeriodRst = 10'd500;
  localparam logic [SetW-1:0]    SetpointMinRst  = 7'd5;
  localparam logic [SetW-1:0]    SetpointMaxRst  = 7'd99;
  localparam logic [SetW-1:0]    SetpointRst     = 7'd85;

  // Input word
  typedef struct packed {
    logic             button_event;
    logic             up_pressed;
    logic             down_pressed;
    logic             toggle_pressed;
    logic             wake_pressed;
    logic             tick_event;
    logic [SoilW-1:0] soil_sample;
  } mpc_in_t;

  // Result word
  typedef struct packed {
    logic            pump_on;
    logic            screen_on;
    logic [SetW-1:0] setpoint_now;
    logic [SetW-1:0] moisture_percent;
    logic            sample_taken;
    logic [SegW-1:0] seg_tens;
    logic [SegW-1:0] seg_units;
  } mpc_out_t;

  // Seven-segment code for one decimal digit, bit0 = segment a
  function automatic logic [SegW-1:0] seg_code(input logic [3:0] digit);
    logic [SegW-1:0] code;
    case (digit)
      4'd0:    code = 7'h3F;
      4'd1:    code = 7'h06;
      4'd2:    code = 7'h5B;
      4'd3:    code = 7'h4F;
      4'd4:    code = 7'h66;
      4'd5:    code = 7'h6D;
      4'd6:    code = 7'h7D;
      4'd7:    code = 7'h07;
      4'd8:    code = 7'h7F;
      4'd9:    code = 7'h6F;
      default: code = 7'h3F;
    endcase
    return code;
  endfunction

  // Quotient by ten of a 7-bit value: (v * 205) >> 11 is exact below 1029
  function automatic logic [3:0] div10(input logic [SetW-1:0] v);
    logic [17:0] prod;
    prod = 18'(v) * 18'd205;
    return prod[14:11];
  endfunction

endpackage

// File: hw/rtl/moisture_pump_controller_unit.sv
// ----------------------------------------------------------------------------
// moisture_pump_controller_unit
// Event-driven moisture pump controller: setpoint buttons, pump toggle,
// screen timeout, periodic soil sampling and setpoint segment codes.
// ----------------------------------------------------------------------------
// Each accepted word is one interrupt event. The block takes one word per
// clock while in_stall is low. Its result goes to the output register, or to
// the one-word skid stage while that register waits, so input keeps flowing;
// in_stall rises only once both hold words. All state (setpoint, pump, screen
// flag, tick counters, last moisture) updates in the same edge that accepts
// the word, through one short combinational pass. Configuration writes
// through the APB port are meant for idle times.
module moisture_pump_controller_unit #(
  parameter int SAMPLE_BITS = mpc_pkg::SAMPLE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  // input channel
  input  logic             in_valid,
  output logic             in_stall,
  input  mpc_pkg::mpc_in_t in_data,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output mpc_pkg::mpc_out_t out_data,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mpc_pkg::*;

  localparam int ProdW = SoilW + 7;
  localparam logic [SoilW-1:0] SampleMask =
      (SAMPLE_BITS >= SoilW) ? {SoilW{1'b1}} : SoilW'((1 << SAMPLE_BITS) - 1);

  // Configuration registers
  logic [SPerW-1:0]   sample_period_r;
  logic [ScrPerW-1:0] screen_period_r;
  logic [SetW-1:0]    setpoint_min_r;
  logic [SetW-1:0]    setpoint_max_r;

  // Controller state
  logic [SetW-1:0]    setpoint_r, setpoint_nxt;
  logic               pump_r, pump_nxt;
  logic               screen_r, screen_nxt;
  logic [SPerW-1:0]   sample_cnt_r, sample_cnt_nxt;
  logic [ScrPerW-1:0] screen_cnt_r, screen_cnt_nxt;
  logic [SetW-1:0]    moisture_r, moisture_nxt;
  logic               taken;

  // Output buffering
  mpc_out_t out_r, skid_r, res;
  logic     out_valid_r, skid_valid_r;
  logic     in_accept, out_fire;

  logic [SoilW-1:0] raw;
  logic [ProdW-1:0] prod;
  logic [SetW-1:0]  pct;
  logic [SetW-1:0]  sp_btn;
  logic [3:0]       quot, tens_d, units_d;
  logic [SetW-1:0]  quot10;
  logic             wr_en;

  // Configuration write and read
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_period_r <= SamplePeriodRst;
      screen_period_r <= ScreenPeriodRst;
      setpoint_min_r  <= SetpointMinRst;
      setpoint_max_r  <= SetpointMaxRst;
    end else if (wr_en) begin
      case (paddr[3:2])
        RegSamplePeriod: sample_period_r <= pwdata[SPerW-1:0];
        RegScreenPeriod: screen_period_r <= pwdata[ScrPerW-1:0];
        RegSetpointMin:  setpoint_min_r  <= pwdata[SetW-1:0];
        RegSetpointMax:  setpoint_max_r  <= pwdata[SetW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegSamplePeriod: prdata = 32'(sample_period_r);
      RegScreenPeriod: prdata = 32'(screen_period_r);
      RegSetpointMin:  prdata = 32'(setpoint_min_r);
      RegSetpointMax:  prdata = 32'(setpoint_max_r);
      default:         prdata = '0;
    endcase
  end

  // Handshake
  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !skid_valid_r;
  assign out_fire  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Soil reading to percent, truncated
  assign raw  = in_data.soil_sample & SampleMask;
  assign prod = ProdW'(raw) * ProdW'(100);
  assign pct  = SetW'(prod >> SAMPLE_BITS);

  // Event evaluation: buttons, wake, then tick
  always_comb begin
    sp_btn         = setpoint_r;
    pump_nxt       = pump_r;
    screen_nxt     = screen_r;
    sample_cnt_nxt = sample_cnt_r;
    screen_cnt_nxt = screen_cnt_r;
    moisture_nxt   = moisture_r;
    taken          = 1'b0;

    if (in_data.button_event) begin
      screen_nxt = 1'b1;
      if (in_data.up_pressed && (setpoint_r < setpoint_max_r)) begin
        sp_btn = setpoint_r + 7'd1;
      end
      if (in_data.down_pressed && (sp_btn > setpoint_min_r)) begin
        sp_btn = sp_btn - 7'd1;
      end
      if (in_data.toggle_pressed) begin
        pump_nxt = !pump_r;
      end
    end
    if (in_data.wake_pressed) begin
      screen_nxt = 1'b1;
    end

    if (in_data.tick_event) begin
      sample_cnt_nxt = sample_cnt_r + 8'd1;
      screen_cnt_nxt = screen_cnt_r + 10'd1;
      if (sample_cnt_nxt >= sample_period_r) begin
        sample_cnt_nxt = '0;
        moisture_nxt   = pct;
        taken          = 1'b1;
        if (pct < sp_btn) begin
          pump_nxt = 1'b1;
        end else if (pct > sp_btn) begin
          pump_nxt = 1'b0;
        end
      end
      if (screen_cnt_nxt >= screen_period_r) begin
        screen_cnt_nxt = '0;
        screen_nxt     = 1'b0;
      end
    end
    setpoint_nxt = sp_btn;
  end

  // Setpoint digits
  assign quot    = div10(setpoint_nxt);
  assign quot10  = SetW'(quot) * 7'd10;
  assign units_d = 4'(setpoint_nxt - quot10);
  assign tens_d  = (quot >= 4'd10) ? (quot - 4'd10) : quot;

  // Result word
  always_comb begin
    res.pump_on          = pump_nxt;
    res.screen_on        = screen_nxt;
    res.setpoint_now     = setpoint_nxt;
    res.moisture_percent = moisture_nxt;
    res.sample_taken     = taken;
    res.seg_tens         = seg_code(tens_d);
    res.seg_units        = seg_code(units_d);
  end

  // Advance controller state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r   <= SetpointRst;
      pump_r       <= 1'b0;
      screen_r     <= 1'b1;
      sample_cnt_r <= '0;
      screen_cnt_r <= '0;
      moisture_r   <= '0;
    end else if (in_accept) begin
      setpoint_r   <= setpoint_nxt;
      pump_r       <= pump_nxt;
      screen_r     <= screen_nxt;
      sample_cnt_r <= sample_cnt_nxt;
      screen_cnt_r <= screen_cnt_nxt;
      moisture_r   <= moisture_nxt;
    end
  end

  // Output register and skid stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Output register and skid stage payload
  always_ff @(posedge clk) begin
    if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (in_accept) begin
        out_r <= res;
      end
    end else if (in_accept) begin
      skid_r <= res;
    end
  end

endmodule
